FILE: design/pdt_pkg.sv
`default_nettype none

package pdt_pkg;

    localparam int MAX_UNIQUE = 256;
    localparam int IDX_W      = $clog2(MAX_UNIQUE);
    localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);

    localparam int POS_W      = 24;
    localparam int HEAD_W     = 16;
    localparam int DIST_W     = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;

    localparam int OUT_IDX_W  = 8;
    localparam int OUT_CNT_W  = 9;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEAD = 1'd1;

    // half a turn in binary angle units
    localparam logic [HEAD_W-1:0] HEAD_HALF = 16'h8000;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [HEAD_W-1:0]       h;
    } t_entry;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_tag;

    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_result;

endpackage

`default_nettype wire

FILE: design/pose_dedup_table_unit.sv
`default_nettype none

// Pose deduplication table. Raise i_start for one cycle while o_busy is low
// to hand in a pose; o_done then pulses for exactly one cycle with the result
// and the receiver cannot hold it off, so capture it on that cycle. With n
// entries in the table an item keeps the block busy until entry k, the first
// match, has passed the compare, or until all n entries have been compared
// when none matches (no scan at all on an empty table); o_done is high in the
// first cycle with o_busy low again. The scan runs through the single read
// port of the entry RAM, one entry per cycle, plus the compare pipeline
// behind it. A new pose may be started in the same cycle as o_done. Write the
// thresholds only while the block is idle.

module pose_dedup_table_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire logic                                i_first_of_set,
    input  wire logic signed [pdt_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic signed [pdt_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic [pdt_pkg::HEAD_W-1:0]          i_heading,
    input  wire logic                                i_cfg_we,
    input  wire logic [pdt_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire logic [pdt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic                                     o_done,
    output logic [pdt_pkg::OUT_IDX_W-1:0]            o_unique_index,
    output logic                                     o_is_new,
    output logic                                     o_overflow,
    output logic [pdt_pkg::OUT_CNT_W-1:0]            o_unique_count
);

    import pdt_pkg::*;

    t_state r_state, n_state;

    logic [DIST_W-1:0] r_min_dist;
    logic [HEAD_W-1:0] r_min_head;

    t_entry            r_pose;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;

    logic                 r_done, n_done;
    logic [OUT_IDX_W-1:0] r_uidx, n_uidx;
    logic                 r_is_new, n_is_new;
    logic                 r_ovf, n_ovf;
    logic [OUT_CNT_W-1:0] r_ucnt, n_ucnt;

    logic    accept;
    logic    issue, flush, drained, wr_en;
    t_tag    issue_tag;
    t_entry  rd_entry;
    t_result res;
    logic    active;

    assign accept = i_start && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= '0;
            r_min_head <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_DIST: r_min_dist <= DIST_W'(i_cfg_wdata);
                CFG_MIN_HEAD: r_min_head <= HEAD_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pose.x <= i_pos_x;
            r_pose.y <= i_pos_y;
            r_pose.h <= i_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_uidx   <= n_uidx;
        r_is_new <= n_is_new;
        r_ovf    <= n_ovf;
        r_ucnt   <= n_ucnt;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        n_done   = 1'b0;
        n_uidx   = r_uidx;
        n_is_new = r_is_new;
        n_ovf    = r_ovf;
        n_ucnt   = r_ucnt;
        issue    = 1'b0;
        flush    = 1'b0;
        wr_en    = 1'b0;
        drained  = (r_rd_idx == r_count) && !active;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state  = ST_SCAN;
                    n_rd_idx = '0;
                    if (i_first_of_set) begin
                        n_count = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (res.vld && res.hit) begin
                    // first match wins: drop reads still in flight
                    flush    = 1'b1;
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_uidx   = OUT_IDX_W'(res.idx);
                    n_is_new = 1'b0;
                    n_ovf    = 1'b0;
                    n_ucnt   = OUT_CNT_W'(r_count);
                end else if (drained) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    if (r_count < CNT_W'(MAX_UNIQUE)) begin
                        wr_en    = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                        n_uidx   = OUT_IDX_W'(r_count);
                        n_is_new = 1'b1;
                        n_ovf    = 1'b0;
                        n_ucnt   = OUT_CNT_W'(r_count + CNT_W'(1));
                    end else begin
                        n_uidx   = '0;
                        n_is_new = 1'b0;
                        n_ovf    = 1'b1;
                        n_ucnt   = OUT_CNT_W'(r_count);
                    end
                end else if (r_rd_idx < r_count) begin
                    issue    = 1'b1;
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign issue_tag.vld = issue;
    assign issue_tag.idx = r_rd_idx[IDX_W-1:0];

    // the append is written as the item ends, before any later read is issued
    pdt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_UNIQUE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_pose),
        .i_re    (issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    pdt_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flush    (flush),
        .i_issue    (issue_tag),
        .i_entry    (rd_entry),
        .i_pose     (r_pose),
        .i_min_dist (r_min_dist),
        .i_min_head (r_min_head),
        .o_res      (res),
        .o_active   (active)
    );

    assign o_busy         = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_unique_index = r_uidx;
    assign o_is_new       = r_is_new;
    assign o_overflow     = r_ovf;
    assign o_unique_count = r_ucnt;

endmodule

`default_nettype wire

FILE: design/pdt_ram.sv
`default_nettype none

module pdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/pdt_match.sv
`default_nettype none

module pdt_match (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_flush,
    input  wire pdt_pkg::t_tag                   i_issue,
    input  wire pdt_pkg::t_entry                 i_entry,
    input  wire pdt_pkg::t_entry                 i_pose,
    input  wire logic [pdt_pkg::DIST_W-1:0]      i_min_dist,
    input  wire logic [pdt_pkg::HEAD_W-1:0]      i_min_head,
    output pdt_pkg::t_result                     o_res,
    output logic                                 o_active
);

    import pdt_pkg::*;

    t_tag r_t0, r_t1, r_t2;

    logic [DIFF_W-1:0] r_ax, r_ay;
    logic              r_hok1, r_hok2;
    logic [SQ_W-1:0]   r_sx, r_sy;

    logic signed [DIFF_W-1:0] dx, dy;
    logic [HEAD_W-1:0]        dh, dh_fold;
    logic [SQ_W-1:0]          dist2;

    // tags follow the RAM read through the compare stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_t0 <= '0;
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            r_t0 <= i_issue;
            r_t1 <= r_t0;
            r_t2 <= r_t1;
        end
    end

    always_comb begin
        dx      = DIFF_W'(i_pose.x) - DIFF_W'(i_entry.x);
        dy      = DIFF_W'(i_pose.y) - DIFF_W'(i_entry.y);
        dh      = i_pose.h - i_entry.h;
        // fold the wrapped difference into 0 .. half a turn
        dh_fold = (dh > HEAD_HALF) ? (HEAD_W'(0) - dh) : dh;
    end

    always_ff @(posedge i_clk) begin
        r_ax   <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        r_ay   <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        r_hok1 <= dh_fold < i_min_head;
        r_sx   <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy   <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_hok2 <= r_hok1;
    end

    assign dist2 = r_sx + r_sy;

    always_comb begin
        o_res.vld = r_t2.vld;
        o_res.idx = r_t2.idx;
        o_res.hit = r_hok2 && (dist2 < SQ_W'(i_min_dist));
        o_active  = r_t0.vld || r_t1.vld || r_t2.vld;
    end

endmodule

`default_nettype wire

FILE: design/pdt_checker.sv
`default_nettype none

module pdt_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_start,
    input wire logic                                o_busy,
    input wire logic                                o_done,
    input wire logic [pdt_pkg::OUT_IDX_W-1:0]       o_unique_index,
    input wire logic                                o_is_new,
    input wire logic                                o_overflow,
    input wire logic [pdt_pkg::OUT_CNT_W-1:0]       o_unique_count
);

    import pdt_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted item did not make the block busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy) && !o_busy)
        else $error("result strobe outside the end of an item");

    a_new_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_is_new && o_overflow))
        else $error("item flagged both new and overflow");

    a_new_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_is_new |->
            o_unique_index == OUT_IDX_W'(o_unique_count - OUT_CNT_W'(1)))
        else $error("appended item index does not match the count");

    a_ovf_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_overflow |-> o_unique_index == '0)
        else $error("overflow item with a non-zero index");

endmodule

bind pose_dedup_table_unit pdt_checker u_pdt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_unique_index (o_unique_index),
    .o_is_new       (o_is_new),
    .o_overflow     (o_overflow),
    .o_unique_count (o_unique_count)
);

`default_nettype wire
